// File: rtl/core/bbldm_pkg.sv
// shared constants, types and register codes of the bayer black level bin demosaic unit
`timescale 1ns / 1ps
package bbldm_pkg;

   // geometry and sample format
   localparam int MAX_LINE_WIDTH = 8192;
   localparam int SAMPLE_BITS    = 16;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
   localparam int WIDTH_W        = 14;
   localparam int ROW_W          = 16;
   localparam int LEVEL_W        = 16;
   localparam int PIX_W          = 18;

   // saturation bounds of signed q2.16
   localparam logic signed [PIX_W-1:0] PIX_MAX = 18'sh1FFFF;
   localparam logic signed [PIX_W-1:0] PIX_MIN = 18'sh20000;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = PIX_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLACK_0 = 3'd0,
      CSR_BLACK_1 = 3'd1,
      CSR_BLACK_2 = 3'd2,
      CSR_BLACK_3 = 3'd3,
      CSR_WHITE   = 3'd4,
      CSR_WIDTH   = 3'd5,
      CSR_PHASE   = 3'd6
   } csr_index_type;

   // configuration as seen by front and back
   typedef struct packed {
      logic [3:0][LEVEL_W-1:0] black_level;
      logic [LEVEL_W-1:0]      white_level;
      logic [WIDTH_W-1:0]      line_width;
      logic [1:0]              bayer_phase;
   } cfg_type;

   // one classified sample on its way to the back end
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_sample;
      logic [1:0]             site;
      logic [COL_W-1:0]       col;
      logic                   window_ok;
      logic                   row_end;
   } work_type;

   // queue fill status
   typedef struct packed {
      logic [QPTR_W:0] count;
      logic            full;
      logic            empty;
   } queue_stat_type;

endpackage

// File: rtl/core/bbldm_csr.sv
// configuration registers of the bayer black level bin demosaic unit
`timescale 1ns / 1ps
module bbldm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bbldm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbldm_pkg::CSR_DATA_W-1:0] csr_data,
   output bbldm_pkg::cfg_type              cfg
);
   import bbldm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BLACK_0: cfg_in.black_level[0] = csr_data[LEVEL_W-1:0];
            CSR_BLACK_1: cfg_in.black_level[1] = csr_data[LEVEL_W-1:0];
            CSR_BLACK_2: cfg_in.black_level[2] = csr_data[LEVEL_W-1:0];
            CSR_BLACK_3: cfg_in.black_level[3] = csr_data[LEVEL_W-1:0];
            CSR_WHITE:   cfg_in.white_level    = csr_data[LEVEL_W-1:0];
            CSR_WIDTH:   cfg_in.line_width     = csr_data[WIDTH_W-1:0];
            CSR_PHASE:   cfg_in.bayer_phase    = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_level <= '0;
         cfg_ff.white_level <= '1;
         cfg_ff.line_width  <= WIDTH_W'(MAX_LINE_WIDTH);
         cfg_ff.bayer_phase <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/bbldm_front.sv
// front end: raster position tracking and bayer site classification
`timescale 1ns / 1ps
module bbldm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [bbldm_pkg::SAMPLE_BITS-1:0]  raw_sample,
   input  logic                               frame_start,
   input  bbldm_pkg::cfg_type                 cfg,
   output bbldm_pkg::work_type                entry
);
   import bbldm_pkg::*;

   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;

   logic [WIDTH_W-1:0] width;
   logic [COL_W-1:0]   col_start;
   logic [ROW_W-1:0]   row_start;
   logic               wrap_early;
   logic [COL_W-1:0]   col;
   logic [ROW_W-1:0]   row;
   logic [WIDTH_W-1:0] col_plus;
   logic               last;

   // row counter wraps to two, keeping parity and window validity
   function automatic logic [ROW_W-1:0] row_next(input logic [ROW_W-1:0] r);
      logic [ROW_W-1:0] n;
      n = (r == '1) ? ROW_W'(2) : r + 1'b1;
      return n;
   endfunction

   // line width in use, clamped
   always_comb begin
      if (cfg.line_width < WIDTH_W'(2)) begin
         width = WIDTH_W'(2);
      end else if (cfg.line_width > WIDTH_W'(MAX_LINE_WIDTH)) begin
         width = WIDTH_W'(MAX_LINE_WIDTH);
      end else begin
         width = cfg.line_width;
      end
   end

   // position of this sample
   always_comb begin
      col_start  = frame_start ? '0 : col_ff;
      row_start  = frame_start ? '0 : row_ff;
      wrap_early = {1'b0, col_start} >= width;
      col        = wrap_early ? '0 : col_start;
      row        = wrap_early ? row_next(row_start) : row_start;
      col_plus   = {1'b0, col} + 1'b1;
      last       = col_plus >= width;
      col_in     = last ? '0 : col_plus[COL_W-1:0];
      row_in     = last ? row_next(row) : row;
   end

   // classified beat
   always_comb begin
      entry.raw_sample = raw_sample;
      entry.site       = {row[0] ^ cfg.bayer_phase[1], col[0] ^ cfg.bayer_phase[0]};
      entry.col        = col;
      entry.window_ok  = (row != '0) && (col != '0);
      entry.row_end    = (col_plus == width);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: rtl/core/bbldm_queue.sv
// short queue between front and back end
`timescale 1ns / 1ps
module bbldm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bbldm_pkg::work_type        din,
   input  logic                       pop,
   output bbldm_pkg::work_type        dout,
   output bbldm_pkg::queue_stat_type  stat
);
   import bbldm_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              do_push;
   logic              do_pop;

   // status
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign dout       = slot_ff[rd_ptr_ff];

   // pointer update
   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: rtl/core/bbldm_back.sv
// back end: normalization divider, line buffer, 2x2 window and result register
`timescale 1ns / 1ps
module bbldm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  bbldm_pkg::cfg_type                 cfg,
   input  logic                               q_empty,
   input  bbldm_pkg::work_type                q_entry,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_red,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_green,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_blue,
   output logic                               rsp_row_end
);
   import bbldm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_PREP = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_NORM = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   work_type                 job_ff;
   logic [LEVEL_W-1:0]       divisor_ff;
   logic [LEVEL_W-1:0]       divisor_in;
   logic signed [LEVEL_W:0]  diff_ff;
   logic signed [LEVEL_W:0]  diff_in;
   logic                     neg_ff;
   logic                     sat_ff;
   logic                     sat_in;
   logic [LEVEL_W-1:0]       rem_ff;
   logic [LEVEL_W-1:0]       rem_in;
   logic [PIX_W-1:0]         low_ff;
   logic [PIX_W-1:0]         low_in;
   logic [PIX_W-1:0]         quo_ff;
   logic [PIX_W-1:0]         quo_in;
   logic [STEP_W-1:0]        step_ff;
   logic signed [PIX_W-1:0]  cur_ff;
   logic signed [PIX_W-1:0]  cur_in;
   logic signed [PIX_W-1:0]  up_ff;
   logic signed [PIX_W-1:0]  left_ff;
   logic signed [PIX_W-1:0]  upleft_ff;
   logic [PIX_W-1:0]         line_buf_ff [MAX_LINE_WIDTH];
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic signed [PIX_W-1:0]  red_ff;
   logic signed [PIX_W-1:0]  green_ff;
   logic signed [PIX_W-1:0]  blue_ff;
   logic                     row_end_ff;

   logic [LEVEL_W-1:0]       black;
   logic [LEVEL_W:0]         span;
   logic [LEVEL_W:0]         mag;
   logic [2*LEVEL_W-1:0]     dividend;
   logic [LEVEL_W:0]         trial;
   logic                     fits;
   logic                     emit_go;
   logic                     emit_write;
   logic signed [PIX_W-1:0]  by_site [4];
   logic signed [PIX_W:0]    green_sum;

   assign q_pop       = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_empty   = !out_valid_ff;
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_row_end = row_end_ff;

   // site black level, signed difference and divisor
   always_comb begin
      black   = cfg.black_level[job_ff.site];
      diff_in = $signed({1'b0, LEVEL_W'(job_ff.raw_sample)}) - $signed({1'b0, black});
      span    = {1'b0, cfg.white_level} - {1'b0, black};
      if (span[LEVEL_W] || (span == '0)) begin
         divisor_in = LEVEL_W'(1);
      end else begin
         divisor_in = span[LEVEL_W-1:0];
      end
   end

   // magnitude, saturation and dividend with the rounding half added
   always_comb begin
      mag      = diff_ff[LEVEL_W] ? $unsigned(-diff_ff) : $unsigned(diff_ff);
      sat_in   = mag >= {divisor_ff, 1'b0};
      dividend = {mag[LEVEL_W-1:0], {LEVEL_W{1'b0}}} + (2*LEVEL_W)'(divisor_ff >> 1);
   end

   // one restoring divide step
   always_comb begin
      trial  = {rem_ff, low_ff[PIX_W-1]};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? LEVEL_W'(trial - {1'b0, divisor_ff}) : trial[LEVEL_W-1:0];
      low_in = {low_ff[PIX_W-2:0], 1'b0};
      quo_in = {quo_ff[PIX_W-2:0], fits};
   end

   // sign and clamp of the rounded quotient
   always_comb begin
      if (neg_ff) begin
         if (sat_ff || (quo_ff > PIX_W'(131072))) begin
            cur_in = PIX_MIN;
         end else begin
            cur_in = $signed(PIX_W'(0) - quo_ff);
         end
      end else begin
         if (sat_ff || (quo_ff > PIX_W'(131071))) begin
            cur_in = PIX_MAX;
         end else begin
            cur_in = $signed(quo_ff);
         end
      end
   end

   // place the four window samples by bayer site
   always_comb begin
      logic [1:0] rel;
      for (int i = 0; i < 4; i++) begin
         rel = 2'(i) ^ job_ff.site;
         case (rel)
            2'd0:    by_site[i] = cur_ff;
            2'd1:    by_site[i] = left_ff;
            2'd2:    by_site[i] = up_ff;
            default: by_site[i] = upleft_ff;
         endcase
      end
      green_sum = PIX_W'(0) + by_site[1] + by_site[2];
   end

   // result slot handoff
   always_comb begin
      emit_go      = (state_ff == ST_EMIT)
                     && (!job_ff.window_ok || !out_valid_ff || rsp_pop);
      emit_write   = emit_go && job_ff.window_ok;
      out_valid_in = (out_valid_ff && !rsp_pop) || emit_write;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_NORM;
         ST_NORM: state_in = ST_EMIT;
         ST_EMIT: if (emit_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         upleft_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (emit_go) begin
            left_ff   <= cur_ff;
            upleft_ff <= up_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_entry;
      end
      if (state_ff == ST_LOAD) begin
         diff_ff    <= diff_in;
         divisor_ff <= divisor_in;
      end
      if (state_ff == ST_PREP) begin
         neg_ff  <= diff_ff[LEVEL_W];
         sat_ff  <= sat_in;
         rem_ff  <= LEVEL_W'(dividend[2*LEVEL_W-1:PIX_W]);
         low_ff  <= dividend[PIX_W-1:0];
         quo_ff  <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + 1'b1;
      end
      if (state_ff == ST_NORM) begin
         cur_ff <= cur_in;
      end
      if (emit_write) begin
         red_ff     <= by_site[0];
         green_ff   <= green_sum[PIX_W:1];
         blue_ff    <= by_site[3];
         row_end_ff <= job_ff.row_end;
      end
   end

   // previous row line buffer
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         up_ff <= $signed(line_buf_ff[job_ff.col]);
      end
      if (emit_go) begin
         line_buf_ff[job_ff.col] <= cur_ff;
      end
   end

endmodule

// File: rtl/core/bayer_black_level_bin_demosaic_unit.sv
// top level of the bayer black level bin demosaic unit
`timescale 1ns / 1ps
//
// channel   ports                                   direction  beat when
// req       req_push req_full req_raw_sample        in         req_push && !req_full
//           req_frame_start
// rsp       rsp_empty rsp_pop rsp_red rsp_green     out        rsp_pop && !rsp_empty
//           rsp_blue rsp_row_end
// csr       csr_valid csr_ready csr_index csr_data  in         csr_valid && csr_ready
//
// in the back end each sample passes through pop, level load, dividend setup,
// 18 steps of the shared restoring divider, clamp and window update.
// the front end classifies one sample per cycle, unless req_full holds it, into a
// four-entry queue, so req_full rises only when four samples wait for the divider.
// a finished pixel sits in the result register; the back end stalls on it only
// when the next sample also yields a pixel. synchronous reset, no clearing pass.
module bayer_black_level_bin_demosaic_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [15:0]                        req_raw_sample,
   input  logic                               req_frame_start,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_red,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_green,
   output logic signed [bbldm_pkg::PIX_W-1:0] rsp_blue,
   output logic                               rsp_row_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbldm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbldm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bbldm_pkg::*;

   cfg_type        cfg;
   work_type       front_entry;
   work_type       q_entry;
   queue_stat_type q_stat;
   logic           req_beat;
   logic           q_pop;

   assign req_full = q_stat.full;
   assign req_beat = req_push && !q_stat.full;

   // configuration registers
   bbldm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // position tracking and classification
   bbldm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_beat),
      .raw_sample  (req_raw_sample[SAMPLE_BITS-1:0]),
      .frame_start (req_frame_start),
      .cfg         (cfg),
      .entry       (front_entry)
   );

   // decoupling queue
   bbldm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_beat),
      .din   (front_entry),
      .pop   (q_pop),
      .dout  (q_entry),
      .stat  (q_stat)
   );

   // normalization, window and result register
   bbldm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_empty     (q_stat.empty),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_row_end (rsp_row_end)
   );

`ifndef ASSERT_OFF
   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // back end only takes a beat that is there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("back end popped an empty queue");

   // queue fill rises by one on a push beat without a pop
   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      (req_beat && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
      else $error("queue count missed a beat");

   // out of reset nothing waits on either side
   a_reset_clear: assert property (@(posedge clock)
      $fell(reset) |-> (!req_full && rsp_empty))
      else $error("state left over after reset");
`endif

endmodule

// File: verif/testbench.sv
// self-checking testbench of the bayer black level bin demosaic unit
`timescale 1ns / 1ps

module testbench;
   import bbldm_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 700;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 5000;

   // one expected rgb pixel
   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             row_end;
   } rgb_pixel_type;

   // predicts pixels from accepted samples and compares the pixels that come out
   class pixel_scoreboard;
      logic [LEVEL_W-1:0] black [4];
      logic [LEVEL_W-1:0] white;
      logic [WIDTH_W-1:0] width_reg;
      logic [1:0]         phase;
      int                 row_store [MAX_LINE_WIDTH];
      int                 left_q;
      int                 upper_left_q;
      int unsigned        col;
      int unsigned        row;
      rgb_pixel_type      expected_pixels [$];
      int                 errors;

      function new();
         foreach (black[s]) black[s] = '0;
         white        = 16'hFFFF;
         width_reg    = 14'd8192;
         phase        = 2'd0;
         foreach (row_store[i]) row_store[i] = 0;
         left_q       = 0;
         upper_left_q = 0;
         col          = 0;
         row          = 0;
         errors       = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BLACK_0: black[0] = data;
            CSR_BLACK_1: black[1] = data;
            CSR_BLACK_2: black[2] = data;
            CSR_BLACK_3: black[3] = data;
            CSR_WHITE:   white = data;
            CSR_WIDTH:   width_reg = data[WIDTH_W-1:0];
            CSR_PHASE:   phase = data[1:0];
            default: ;
         endcase
      endfunction

      // width register as the block uses it
      function int unsigned effective_width(logic [WIDTH_W-1:0] w);
         if (w < 2) return 2;
         if (w > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
         return w;
      endfunction

      // black subtract and scale to q2.16, round half away from zero, saturate
      function int normalize_q(logic [SAMPLE_BITS-1:0] raw, logic [1:0] site);
         longint lvl, divisor, q, mag, res;
         lvl = longint'(black[site]);
         divisor = longint'(white) - lvl;
         if (divisor < 1) divisor = 1;
         q = (longint'(raw) - lvl) * 65536;
         mag = (q < 0) ? -q : q;
         res = (mag + divisor / 2) / divisor;
         if (q < 0) res = -res;
         if (res > longint'(PIX_MAX)) res = longint'(PIX_MAX);
         if (res < longint'(PIX_MIN)) res = longint'(PIX_MIN);
         return int'(res);
      endfunction

      // advance the window by one accepted sample
      function void note_sample(logic [SAMPLE_BITS-1:0] raw, bit fs);
         int unsigned   w;
         logic [1:0]    site;
         int            cur;
         int            up;
         int            by_site [4];
         int            green_sum;
         rgb_pixel_type px;
         w = effective_width(width_reg);
         if (fs) begin
            col = 0;
            row = 0;
         end
         // width shrunk under the current column starts a new row
         if (col >= w) begin
            col = 0;
            row = (row >= 65535) ? 2 : row + 1;
         end
         site = {row[0] ^ phase[1], col[0] ^ phase[0]};
         cur = normalize_q(raw, site);
         up = row_store[col];
         if (row >= 1 && col >= 1) begin
            by_site[site]         = cur;
            by_site[site ^ 2'd1]  = left_q;
            by_site[site ^ 2'd2]  = up;
            by_site[site ^ 2'd3]  = upper_left_q;
            green_sum = by_site[1] + by_site[2];
            px.red     = by_site[0][PIX_W-1:0];
            px.green   = (green_sum >>> 1) & 32'h3FFFF;
            px.blue    = by_site[3][PIX_W-1:0];
            px.row_end = (col + 1 == w);
            expected_pixels.push_back(px);
         end
         upper_left_q = up;
         left_q = cur;
         row_store[col] = cur;
         if (col + 1 >= w) begin
            col = 0;
            row = (row >= 65535) ? 2 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, $signed(want), $signed(got));
         end
      endfunction

      function void check_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                                logic [PIX_W-1:0] blue, logic row_end);
         rgb_pixel_type px;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel, expected none actual r=%0d g=%0d b=%0d end=%0d",
                     $time, $signed(red), $signed(green), $signed(blue), row_end);
            return;
         end
         px = expected_pixels.pop_front();
         compare_field("red", px.red, red);
         compare_field("green", px.green, green);
         compare_field("blue", px.blue, blue);
         compare_field("row_end", {17'd0, px.row_end}, {17'd0, row_end});
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [15:0]           req_raw_sample = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic signed [PIX_W-1:0] rsp_red;
   logic signed [PIX_W-1:0] rsp_green;
   logic signed [PIX_W-1:0] rsp_blue;
   logic                  rsp_row_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pixel_scoreboard board = new();
   bit  steady_flow = 1'b0;
   bit  hold_request = 1'b0;
   int  idle_cycles = 0;

   bayer_black_level_bin_demosaic_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_raw_sample  (req_raw_sample),
      .req_frame_start (req_frame_start),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_row_end     (rsp_row_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // pixel receiver with random stalls and one long hold-off on request
   initial begin
      int wait_cycles;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         wait_cycles = steady_flow ? 0 : $urandom_range(0, 4);
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.check_pixel(rsp_red, rsp_green, rsp_blue, rsp_row_end);
      end
   end

   // write all seven registers, starting at a random one
   task automatic set_config(logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                             logic [15:0] b3, logic [15:0] white, logic [15:0] width,
                             logic [15:0] phase);
      logic [15:0]   values [7];
      int            first;
      csr_index_type idx;
      values = '{b0, b1, b2, b3, white, width, phase};
      first = $urandom_range(0, 6);
      for (int k = 0; k < 7; k++) begin
         idx = csr_index_type'((first + k) % 7);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= values[idx];
         do @(posedge clock); while (!csr_ready);
         board.write_register(idx, values[idx]);
      end
      csr_valid <= 1'b0;
   endtask

   // one sample beat, then the sender's gap
   task automatic push_sample(logic [15:0] raw, bit fs, bit last);
      int gap;
      req_push        <= 1'b1;
      req_raw_sample  <= raw;
      req_frame_start <= fs;
      do @(posedge clock); while (req_full);
      board.note_sample(raw, fs);
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (last || gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_list(logic [15:0] list [$], bit new_frame);
      foreach (list[i]) push_sample(list[i], new_frame && i == 0, i == list.size() - 1);
   endtask

   // all pixels in, then room for samples that yield none
   task automatic wait_idle();
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_black();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return $urandom_range(0, 65535);
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return board.black[$urandom_range(0, 3)] + $urandom_range(0, 6) - 3;
         3: return board.white + $urandom_range(0, 6) - 3;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // stimulus
   initial begin
      logic [15:0] b [4];
      logic [15:0] white_data;
      logic [15:0] width_data;
      int unsigned eff_width;
      int unsigned cur_width;
      bit          continue_frame;
      bit          pressure;
      int          n;
      int          phase_no;
      int          random_items;
      logic [15:0] list [$];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // width below range, raw extremes, rows of two
      set_config(16'd256, 16'd512, 16'd768, 16'd1024, 16'd4096, 16'd0, 16'd0);
      list = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd12345, 16'd40};
      send_list(list, 1'b1);
      wait_idle();

      // white at black, width above range: one partial row, no pixel
      set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd3);
      list = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000};
      send_list(list, 1'b1);
      wait_idle();
      // width shrunk mid row, frame continues
      set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd3);
      list = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
      send_list(list, 1'b0);
      wait_idle();

      // full scale black levels, odd width
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'd1);
      list = '{16'h0000, 16'hFFFF, 16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000, 16'd100};
      send_list(list, 1'b1);
      wait_idle();
      cur_width = 3;

      // random phases of rows with random content
      phase_no = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase_no++;
         pressure = (phase_no == 3);
         foreach (b[s]) b[s] = pick_black();
         case ($urandom_range(0, 9))
            0: white_data = 16'hFFFF;
            1: white_data = 16'h0000;
            2: white_data = $urandom_range(0, 65535);
            3: white_data = b[$urandom_range(0, 3)];
            default: white_data = $urandom_range(8192, 65535);
         endcase
         case ($urandom_range(0, 11))
            0: width_data = 16'd0;
            1: width_data = 16'd1;
            2: width_data = 16'hFFFF;
            3: width_data = 16'd8192;
            4: width_data = $urandom_range(8193, 16383);
            5: width_data = $urandom_range(0, 65535);
            default: width_data = $urandom_range(2, 12);
         endcase
         if (pressure) width_data = 16'd4;
         eff_width = board.effective_width(width_data[WIDTH_W-1:0]);
         // a frame may only go on when no line buffer entry beyond it is needed
         continue_frame = (eff_width <= cur_width) && ($urandom_range(0, 3) == 0);
         set_config(b[0], b[1], b[2], b[3], white_data, width_data, $urandom_range(0, 65535));
         cur_width = eff_width;
         if (eff_width <= 64)
            n = eff_width * $urandom_range(2, 5) + $urandom_range(0, eff_width - 1);
         else
            n = $urandom_range(1, 16);
         if (pressure && n < 24) n = 24;
         steady_flow = pressure || ($urandom_range(0, 3) == 0);
         if (pressure) hold_request = 1'b1;
         for (int i = 0; i < n; i++)
            push_sample(pick_raw(), (i == 0 && !continue_frame) || ($urandom_range(0, 49) == 0),
                        i == n - 1);
         random_items += n;
         wait_idle();
      end

      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/bbldm_pkg.sv
rtl/core/bbldm_csr.sv
rtl/core/bbldm_front.sv
rtl/core/bbldm_queue.sv
rtl/core/bbldm_back.sv
rtl/core/bayer_black_level_bin_demosaic_unit.sv
verif/testbench.sv
